@@ hdl/dtb_pkg.sv @@
// Shared types and constants for the DMA descriptor table builder.
// Used by every module of the block and by its checker.
package dtb_pkg;

  localparam int unsigned DTB_CHUNK_BYTES   = 4096;
  localparam int unsigned DTB_TABLE_ENTRIES = 256;

  localparam int unsigned ALIGN_W = 13;
  localparam int unsigned MAXX_W  = 17;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SLOT_W  = 4;

  localparam logic [SLOT_W-1:0] LAST_SLOT   = 4'd15;
  localparam logic [LEN_W-1:0]  SEG_MAX     = 17'd65536;
  localparam logic [ALIGN_W-1:0] ALIGN_RST  = 13'd2;
  localparam logic [MAXX_W-1:0]  MAXX_RST   = 17'd65536;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BUSY       = 3'd1,
    ST_ZERO_LEN   = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_OVERSIZED  = 3'd4,
    ST_NOT_LOAD   = 3'd5,
    ST_TABLE_FULL = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_SEGMENT = 2'd1,
    OP_FINISH  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic {
    REG_ALIGN = 1'b0,
    REG_MAXX  = 1'b1
  } reg_e;

  typedef struct packed {
    logic [LEN_W-1:0]  count;
    logic [LEN_W-1:0]  next_off;
    logic [ADDR_W-1:0] base;
    logic              last;
  } chunk_res_t;

endpackage

@@ hdl/dtb_chunk_alu.sv @@
// Chunk splitter unit: one chunk of a segment per use, reused for each chunk.
// Depends on dtb_pkg.
module dtb_chunk_alu #(
  parameter int unsigned CHUNK_BYTES = dtb_pkg::DTB_CHUNK_BYTES
) (
  input  logic [dtb_pkg::ADDR_W-1:0] seg_addr_i,
  input  logic [dtb_pkg::LEN_W-1:0]  seg_len_i,
  input  logic [dtb_pkg::LEN_W-1:0]  off_i,
  input  logic                       last_slot_i,
  output dtb_pkg::chunk_res_t        res_o
);
  import dtb_pkg::*;

  localparam logic [LEN_W-1:0] CHUNK = LEN_W'(CHUNK_BYTES);

  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] cnt;

  always_comb begin
    rem = seg_len_i - off_i;
    cnt = (last_slot_i || rem < CHUNK) ? rem : CHUNK;
    res_o.count    = cnt;
    res_o.next_off = off_i + cnt;
    res_o.base     = seg_addr_i + {{(ADDR_W-LEN_W){1'b0}}, off_i};
    res_o.last     = (cnt == rem);
  end

endmodule

@@ hdl/dma_descriptor_table_builder.sv @@
// DMA descriptor table builder, top level: sequencer, state and output word register.
// Depends on dtb_pkg and dtb_chunk_alu.
//
// Input channel (in_valid_i / in_stall_o) takes one word: start, segment or finish.
// Output channel (out_valid_o / out_stall_i) returns one or more result words per
// input word; run_last_o marks the last one. The block works on one input word at
// a time and holds in_stall_o high until the last result is in the output register.
// Start, finish and ignored ops: one result, formed in S_EXEC and then registered.
// Segment: S_EXEC sizes the table check, then S_EMIT loads one descriptor per cycle
// from the shared chunk unit while the output is not stalled (up to 16 chunks, 16
// for a 64 KiB segment in 4 KiB chunks); a segment not in loading phase: one result.
// The next word is accepted the cycle after the last result is loaded.
// A stalled output register holds its word and the sequencer waits on it.
// Reset (rst_ni low, asynchronous) clears phase, direction and table position,
// empties the output register and sets align_bytes to 2, max_transfer to 65536.
// The config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes one register per cycle
// and is to be used only while the block is idle.
module dma_descriptor_table_builder #(
  parameter int unsigned CHUNK_BYTES   = dtb_pkg::DTB_CHUNK_BYTES,
  parameter int unsigned TABLE_ENTRIES = dtb_pkg::DTB_TABLE_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] req_addr_i,
  input  logic [17:0] req_count_i,
  input  logic        req_dir_i,
  input  logic [31:0] seg_addr_i,
  input  logic [16:0] seg_len_i,
  input  logic        seg_final_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        entry_valid_o,
  output logic [7:0]  entry_index_o,
  output logic [31:0] entry_base_o,
  output logic [15:0] entry_count_o,
  output logic        entry_eot_o,
  output logic        run_last_o,
  output logic        xfer_active_o,
  output logic        xfer_read_o
);
  import dtb_pkg::*;

  localparam int unsigned ENT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned PROD_W = SLOT_W + LEN_W + 1;
  localparam logic [ENT_W-1:0] TABLE_N = ENT_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_LOADING = 3'b010,
    PH_ACTIVE  = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   read_q, read_d;
  logic [ENT_W-1:0]  next_entry_q, next_entry_d;
  logic [LEN_W-1:0]  off_q, off_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic full_q, full_d;

  logic [ALIGN_W-1:0] align_q;
  logic [MAXX_W-1:0]  maxx_q;

  op_e               op_q;
  logic [ADDR_W-1:0] req_addr_q;
  logic [CNT_W-1:0]  req_count_q;
  logic              req_dir_q;
  logic [ADDR_W-1:0] seg_addr_q;
  logic [LEN_W-1:0]  seg_len_q;
  logic              fin_q;

  logic              out_valid_q;
  status_e           out_status_q, o_status;
  logic              out_ev_q, o_ev;
  logic [7:0]        out_idx_q, o_idx;
  logic [ADDR_W-1:0] out_base_q, o_base;
  logic [15:0]       out_cnt_q, o_cnt;
  logic              out_eot_q, o_eot;
  logic              out_last_q, o_last;
  logic              out_act_q, o_act;
  logic              out_rd_q, o_rd;

  logic out_ld, produce, accept;
  logic [ALIGN_W-1:0] mask;
  logic [ENT_W-1:0]   free_n;
  logic [ENT_W+4:0]   free_x;
  logic [PROD_W-1:0]  room;
  logic [ENT_W+7:0]   idx_x;
  logic               seg_act;
  chunk_res_t         chunk;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_ld     = !out_valid_q || !out_stall_i;
  assign mask       = align_q - ALIGN_W'(1);
  assign free_n     = TABLE_N - next_entry_q;
  assign free_x     = {5'b0, free_n};
  assign room       = PROD_W'(free_x[3:0]) * PROD_W'(CHUNK_BYTES);
  assign idx_x      = {8'b0, next_entry_q};
  assign seg_act    = fin_q && !full_q;

  dtb_chunk_alu #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) u_alu (
    .seg_addr_i (seg_addr_q),
    .seg_len_i  (seg_len_q),
    .off_i      (off_q),
    .last_slot_i(slot_q == LAST_SLOT),
    .res_o      (chunk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= ALIGN_RST;
      maxx_q  <= MAXX_RST;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_ALIGN: align_q <= cfg_data_i[ALIGN_W-1:0];
        REG_MAXX:  maxx_q  <= cfg_data_i[MAXX_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_e'(op_i);
      req_addr_q  <= req_addr_i;
      req_count_q <= req_count_i;
      req_dir_q   <= req_dir_i;
      seg_addr_q  <= seg_addr_i;
      seg_len_q   <= (seg_len_i > SEG_MAX) ? SEG_MAX : seg_len_i;
      fin_q       <= seg_final_i;
    end
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    read_d       = read_q;
    next_entry_d = next_entry_q;
    off_d        = off_q;
    slot_d       = slot_q;
    full_d       = full_q;
    produce      = 1'b0;
    o_status     = ST_OK;
    o_ev         = 1'b0;
    o_idx        = '0;
    o_base       = '0;
    o_cnt        = '0;
    o_eot        = 1'b0;
    o_last       = 1'b1;
    o_act        = 1'b0;
    o_rd         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_ld) begin
          produce = 1'b1;
          state_d = S_IDLE;
          unique case (op_q)
            OP_START: begin
              if (phase_q != PH_IDLE) begin
                o_status = ST_BUSY;
              end else if (req_count_q == '0) begin
                o_status = ST_ZERO_LEN;
              end else if ((req_addr_q[ALIGN_W-1:0] & mask) != '0 ||
                           (req_count_q[ALIGN_W-1:0] & mask) != '0) begin
                o_status = ST_MISALIGNED;
              end else if (req_count_q > {1'b0, maxx_q}) begin
                o_status = ST_OVERSIZED;
              end else begin
                phase_d      = PH_LOADING;
                read_d       = req_dir_q;
                next_entry_d = '0;
              end
            end
            OP_SEGMENT: begin
              if (phase_q != PH_LOADING) begin
                o_status = ST_NOT_LOAD;
              end else if (seg_len_q == '0) begin
                if (fin_q) phase_d = PH_ACTIVE;
              end else begin
                produce = 1'b0;
                state_d = S_EMIT;
                off_d   = '0;
                slot_d  = '0;
                full_d  = (free_x < (ENT_W+5)'(16)) && (room < PROD_W'(seg_len_q));
              end
            end
            OP_FINISH: begin
              phase_d      = PH_IDLE;
              read_d       = 1'b0;
              next_entry_d = '0;
            end
            default: ;
          endcase
          o_act = (phase_d == PH_ACTIVE);
          o_rd  = o_act && read_d;
        end
      end
      S_EMIT: begin
        if (out_ld) begin
          produce = 1'b1;
          o_act   = seg_act;
          o_rd    = seg_act && read_q;
          if (next_entry_q >= TABLE_N) begin
            o_status = ST_TABLE_FULL;
            state_d  = S_IDLE;
          end else begin
            o_ev         = 1'b1;
            o_idx        = idx_x[7:0];
            o_base       = chunk.base;
            o_cnt        = chunk.count[15:0];
            o_last       = chunk.last;
            o_eot        = chunk.last && fin_q;
            next_entry_d = next_entry_q + ENT_W'(1);
            off_d        = chunk.next_off;
            slot_d       = slot_q + SLOT_W'(1);
            if (chunk.last) begin
              state_d = S_IDLE;
              if (seg_act) phase_d = PH_ACTIVE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_IDLE;
      read_q       <= 1'b0;
      next_entry_q <= '0;
      off_q        <= '0;
      slot_q       <= '0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      read_q       <= read_d;
      next_entry_q <= next_entry_d;
      off_q        <= off_d;
      slot_q       <= slot_d;
      full_q       <= full_d;
      if (out_ld) out_valid_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld && produce) begin
      out_status_q <= o_status;
      out_ev_q     <= o_ev;
      out_idx_q    <= o_idx;
      out_base_q   <= o_base;
      out_cnt_q    <= o_cnt;
      out_eot_q    <= o_eot;
      out_last_q   <= o_last;
      out_act_q    <= o_act;
      out_rd_q     <= o_rd;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_valid_o = out_ev_q;
  assign entry_index_o = out_idx_q;
  assign entry_base_o  = out_base_q;
  assign entry_count_o = out_cnt_q;
  assign entry_eot_o   = out_eot_q;
  assign run_last_o    = out_last_q;
  assign xfer_active_o = out_act_q;
  assign xfer_read_o   = out_rd_q;

endmodule

@@ hdl/dtb_checker.sv @@
// Port-level checks for the DMA descriptor table builder, bound to the top level.
// Depends on dtb_pkg.
module dtb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        entry_valid_o,
  input logic [31:0] entry_base_o,
  input logic        entry_eot_o,
  input logic        run_last_o,
  input logic        xfer_active_o,
  input logic        xfer_read_o
);
  import dtb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(entry_base_o))
    else $error("stalled output word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  a_desc_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> status_o == ST_OK)
    else $error("descriptor with error status");

  a_eot_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_eot_o |-> run_last_o && xfer_active_o && entry_valid_o)
    else $error("end-of-table word not final or not active");

  a_read_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && xfer_read_o |-> xfer_active_o)
    else $error("read direction shown without active transfer");

endmodule

bind dma_descriptor_table_builder dtb_checker u_dtb_checker (.*);
